[rtl/rrtd_pkg.sv]
// shared types and constants of the round-robin task dispatcher
package rrtd_pkg;

  localparam int TASK_LIMIT_DEF = 128;
  localparam int PROCESSORS_DEF = 4;
  localparam logic [15:0] BUDGET_RESET = 16'd10;

  typedef enum logic [1:0] {
    ACT_CREATE   = 2'd0,
    ACT_SELECT   = 2'd1,
    ACT_COMPLETE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    STS_LOADED   = 3'd0,
    STS_WAITING  = 3'd1,
    STS_FULL     = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_REQUEUED = 3'd4,
    STS_FINISHED = 3'd5,
    STS_SELECTED = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0] action;
    logic       finished;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  task_id;
    logic [1:0]  processor;
    logic [15:0] budget;
    logic        handed_valid;
    logic [7:0]  handed_task;
  } res_t;

endpackage

[rtl/rrtd_ring_mem.sv]
// ring storage with one write port and one registered, write-through read port
module rrtd_ring_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // new head written this cycle is seen at once
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rrtd_sched.sv]
// scheduler state, ready and wait rings, and the per-request decision logic
module rrtd_sched #(
  parameter int TASK_LIMIT = rrtd_pkg::TASK_LIMIT_DEF,
  parameter int PROCESSORS = rrtd_pkg::PROCESSORS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  rrtd_pkg::req_t req,
  input  logic [15:0]    slice_budget,
  output rrtd_pkg::res_t result
);

  import rrtd_pkg::*;

  localparam int AW     = $clog2(TASK_LIMIT);
  localparam int CW     = $clog2(TASK_LIMIT + 1);
  localparam int PW     = (PROCESSORS > 1) ? $clog2(PROCESSORS) : 1;
  localparam int RE_W   = PW + CW;

  logic [AW-1:0]         rhead, rhead_next, whead, whead_next;
  logic [CW-1:0]         rfill, rfill_next, wfill, wfill_next;
  logic [CW-1:0]         created, created_next;
  logic [PROCESSORS-1:0] free, free_next;

  logic            r_we, w_we;
  logic [RE_W-1:0] r_wdata, r_rdata;
  logic [CW-1:0]   w_wdata, w_rdata;
  logic [AW-1:0]   r_tail, w_tail;
  logic [CW:0]     r_sum, w_sum;

  logic [CW-1:0] new_pid, head_pid;
  logic [PW-1:0] head_proc, pick;

  // tail = head + fill, wrapped on the ring depth
  always_comb begin
    r_sum = (CW+1)'(rhead) + (CW+1)'(rfill);
    w_sum = (CW+1)'(whead) + (CW+1)'(wfill);
    r_tail = (r_sum >= (CW+1)'(TASK_LIMIT)) ? AW'(r_sum - (CW+1)'(TASK_LIMIT)) : AW'(r_sum);
    w_tail = (w_sum >= (CW+1)'(TASK_LIMIT)) ? AW'(w_sum - (CW+1)'(TASK_LIMIT)) : AW'(w_sum);
  end

  // lowest free processor
  always_comb begin
    pick = '0;
    for (int i = PROCESSORS - 1; i >= 0; i--) begin
      if (free[i]) pick = PW'(i);
    end
  end

  assign new_pid   = CW'(created + 1'b1);
  assign head_pid  = r_rdata[CW-1:0];
  assign head_proc = r_rdata[RE_W-1:CW];

  always_comb begin
    rhead_next   = rhead;
    rfill_next   = rfill;
    whead_next   = whead;
    wfill_next   = wfill;
    created_next = created;
    free_next    = free;
    r_we         = 1'b0;
    r_wdata      = r_rdata;
    w_we         = 1'b0;
    w_wdata      = new_pid;
    result       = '0;
    if (fire) begin
      case (req.action)
        ACT_CREATE: begin
          if (created == CW'(TASK_LIMIT)) begin
            result.status = STS_FULL;
          end else begin
            created_next   = CW'(created + 1'b1);
            result.task_id = 8'(new_pid);
            if (|free) begin
              free_next[pick]  = 1'b0;
              r_we             = 1'b1;
              r_wdata          = {pick, new_pid};
              rfill_next       = CW'(rfill + 1'b1);
              result.status    = STS_LOADED;
              result.processor = 2'(pick);
            end else begin
              w_we          = 1'b1;
              wfill_next    = CW'(wfill + 1'b1);
              result.status = STS_WAITING;
            end
          end
        end
        ACT_SELECT, ACT_COMPLETE: begin
          if (rfill == '0) begin
            result.status = STS_EMPTY;
          end else if (req.action == ACT_SELECT) begin
            result.status    = STS_SELECTED;
            result.task_id   = 8'(head_pid);
            result.processor = 2'(head_proc);
            result.budget    = slice_budget;
          end else begin
            rhead_next       = (rhead == AW'(TASK_LIMIT - 1)) ? '0 : AW'(rhead + 1'b1);
            result.task_id   = 8'(head_pid);
            result.processor = 2'(head_proc);
            if (!req.finished) begin
              // back to the tail, fill unchanged
              r_we          = 1'b1;
              result.status = STS_REQUEUED;
            end else if (wfill != '0) begin
              // freed processor goes straight to the oldest waiting task
              whead_next          = (whead == AW'(TASK_LIMIT - 1)) ? '0 : AW'(whead + 1'b1);
              wfill_next          = CW'(wfill - 1'b1);
              r_we                = 1'b1;
              r_wdata             = {head_proc, w_rdata};
              result.status       = STS_FINISHED;
              result.handed_valid = 1'b1;
              result.handed_task  = 8'(w_rdata);
            end else begin
              free_next[head_proc] = 1'b1;
              rfill_next           = CW'(rfill - 1'b1);
              result.status        = STS_FINISHED;
            end
          end
        end
        default: begin
          result = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rhead   <= '0;
      rfill   <= '0;
      whead   <= '0;
      wfill   <= '0;
      created <= '0;
      free    <= '1;
    end else begin
      rhead   <= rhead_next;
      rfill   <= rfill_next;
      whead   <= whead_next;
      wfill   <= wfill_next;
      created <= created_next;
      free    <= free_next;
    end
  end

  // both rings read the next head every cycle so the head entry is always at hand
  rrtd_ring_mem #(
    .DEPTH (TASK_LIMIT),
    .WIDTH (RE_W)
  ) u_ready_ring (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_tail),
    .wdata (r_wdata),
    .raddr (rhead_next),
    .rdata (r_rdata)
  );

  rrtd_ring_mem #(
    .DEPTH (TASK_LIMIT),
    .WIDTH (CW)
  ) u_wait_ring (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_tail),
    .wdata (w_wdata),
    .raddr (whead_next),
    .rdata (w_rdata)
  );

endmodule

[rtl/round_robin_task_dispatcher.sv]
// round-robin task dispatcher: top level with handshakes and slice budget register
// a request accepted into the pending register has its result registered on rsp_data when it fires
// throughput: one request per cycle while rsp_ready stays high, set by the prefetched head read of each ring memory
// result register and pending request register keep both sides moving under stalls
// reset (rst, synchronous): queues empty, all processors free, pid counter at zero (first pid one),
// slice budget 10; ring contents are not cleared and need no clearing pass
module round_robin_task_dispatcher #(
  parameter int TASK_LIMIT = rrtd_pkg::TASK_LIMIT_DEF,
  parameter int PROCESSORS = rrtd_pkg::PROCESSORS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rrtd_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rrtd_pkg::res_t rsp_data,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data
);

  import rrtd_pkg::*;

  logic        pend_valid;
  req_t        pend;
  logic        fire;
  res_t        result;
  logic [15:0] slice_budget;

  // a pending request is worked on once the result register is free or being emptied
  assign fire      = pend_valid && (!rsp_valid || rsp_ready);
  // the pending register takes a new request while the current one moves on
  assign req_ready = !pend_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (req_ready) begin
      pend_valid <= req_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      pend <= req_data;
    end
  end

  // slice budget; the user must write it only while idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_budget <= BUDGET_RESET;
    end else if (cfg_we) begin
      slice_budget <= cfg_data;
    end
  end

  // all queue and processor bookkeeping for the pending request
  rrtd_sched #(
    .TASK_LIMIT (TASK_LIMIT),
    .PROCESSORS (PROCESSORS)
  ) u_sched (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .req          (pend),
    .slice_budget (slice_budget),
    .result       (result)
  );

  // result register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_data <= result;
    end
  end

endmodule

[rtl/rrtd_checker.sv]
// port-level checker for the dispatcher and its bind
module rrtd_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input rrtd_pkg::req_t req_data,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input rrtd_pkg::res_t rsp_data
);

  import rrtd_pkg::*;

  // a waiting request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req_data))
    else $error("request changed while waiting");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // budget is only reported on a select
  a_budget_select: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.budget != 16'd0) |-> rsp_data.status == STS_SELECTED)
    else $error("budget outside select");

  // hand-over only on a finished slice
  a_handed_finished: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.handed_valid |-> rsp_data.status == STS_FINISHED)
    else $error("hand-over without finish");

  // empty queue and full table carry no task
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == STS_EMPTY || rsp_data.status == STS_FULL)
    |-> rsp_data.task_id == 8'd0 && rsp_data.processor == 2'd0 && !rsp_data.handed_valid)
    else $error("empty or full result carries a task");

endmodule

bind round_robin_task_dispatcher rrtd_checker u_rrtd_checker (.*);
